>>> design/ad16_pkg.sv
// ad16_pkg: shared constants and types for the 16-bit arithmetic decoder
// no dependencies
package ad16_pkg;
    localparam int MAX_SYMBOLS_DEF = 256;
    localparam int CODE_BITS_DEF   = 16;
    localparam int FREQ_BITS_DEF   = 14;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_START  = 2'd1,
        CMD_DECODE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic {
        REG_SYMBOL_COUNT = 1'b0,
        REG_TOTAL_FREQ   = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic start;
        logic busy;
    } div_ctl_t;
endpackage

>>> design/ad16_if.sv
// ad16_if: valid/ready channel interfaces for items, results and config
// depends on nothing; payload widths are fixed by the field list
interface ad16_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [8:0]  entry_index;
    logic [13:0] entry_bound;
    logic [7:0]  entry_symbol;
    logic [15:0] code_window;
    modport source (output valid, cmd, entry_index, entry_bound, entry_symbol,
                    code_window, input ready);
    modport sink (input valid, cmd, entry_index, entry_bound, entry_symbol,
                  code_window, output ready);
endinterface

interface ad16_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       end_of_message;
    logic [4:0] bits_used;
    modport source (output valid, symbol, end_of_message, bits_used, input ready);
    modport sink (input valid, symbol, end_of_message, bits_used, output ready);
endinterface

interface ad16_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [13:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> design/ad16_div.sv
// ad16_div: restoring divider, one quotient bit per cycle
// depends on ad16_pkg
module ad16_div #(
    parameter int NW = 32,
    parameter int DW = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ad16_pkg::div_ctl_t  ctl,
    input  logic [NW-1:0]       numer,
    input  logic [DW-1:0]       denom,
    output logic                done,
    output logic [NW-1:0]       quot
);
    localparam int CW = $clog2(NW + 1);
    logic [DW:0]   rem_reg, rem_next;
    logic [NW-1:0] q_reg, q_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic [DW+1:0] trial;

    always_comb
    begin
        rem_next = rem_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        trial    = {rem_reg, q_reg[NW-1]} - {2'b00, denom};
        if (ctl.start)
        begin
            rem_next = '0;
            q_next   = numer;
            cnt_next = CW'(NW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!trial[DW+1])
            begin
                rem_next = trial[DW:0];
            end
            else
            begin
                rem_next = {rem_reg[DW-1:0], q_reg[NW-1]};
            end
            q_next   = {q_reg[NW-2:0], ~trial[DW+1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done = ctl.busy && !run_reg && !ctl.start;
    assign quot = q_reg;
endmodule

>>> design/arithmetic_decoder_16bit_core.sv
// arithmetic_decoder_16bit_core: static-model arithmetic decoder top level
// depends on ad16_pkg, ad16_if (channels) and ad16_div
//
//  channel   dir   payload
//  in_ch     in    cmd, entry_index, entry_bound, entry_symbol, code_window
//  out_ch    out   symbol, end_of_message, bits_used
//  cfg_ch    in    index (0 symbol_count, 1 total_frequency), data
//
// decode runs from accept to result through the scale pass of the shared divider,
// a search over ranks through the registered table read (S_SRCH, S_SRCHW), two more
// divider passes (S_HIDIV, S_LODIV), renormalization one bit per step, and S_SYM,
// S_SYMW and S_OUT for symbol read and output; load and start are taken in S_IDLE
// reset sets a full interval, code 0, symbol_count 1 and total_frequency 2; tables are undefined until loaded
// in_ch is not ready while a word is in work or a result waits on out_ch
module arithmetic_decoder_16bit_core #(
    parameter int MAX_SYMBOLS = ad16_pkg::MAX_SYMBOLS_DEF,
    parameter int CODE_BITS   = ad16_pkg::CODE_BITS_DEF,
    parameter int FREQ_BITS   = ad16_pkg::FREQ_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    ad16_in_if.sink       in_ch,
    ad16_out_if.source    out_ch,
    ad16_cfg_if.sink      cfg_ch
);
    localparam int AW = $clog2(MAX_SYMBOLS);
    localparam int NW = CODE_BITS + FREQ_BITS + 1;
    localparam int RW = AW + 2;
    localparam int UW = $clog2(CODE_BITS + 1);
    localparam logic [CODE_BITS-1:0] HALFV = CODE_BITS'(1) << (CODE_BITS - 1);
    localparam logic [CODE_BITS-1:0] QTRV  = CODE_BITS'(1) << (CODE_BITS - 2);
    localparam logic [CODE_BITS-1:0] Q3V   = HALFV + QTRV;

    // one-hot sequencer
    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_SCALE  = 10'b0000000010,
        S_SRCH   = 10'b0000000100,
        S_SRCHW  = 10'b0000001000,
        S_HIDIV  = 10'b0000010000,
        S_LODIV  = 10'b0000100000,
        S_RENORM = 10'b0001000000,
        S_SYM    = 10'b0010000000,
        S_SYMW   = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // config
    logic [8:0]           count_cfg_reg;
    logic [FREQ_BITS-1:0] freq_cfg_reg;

    // coder state
    logic [CODE_BITS-1:0] low_reg, high_reg, code_reg;
    logic [CODE_BITS-1:0] lo_w_reg, hi_w_reg;
    logic [CODE_BITS-1:0] span_m1_reg;
    logic [CODE_BITS-1:0] window_reg;
    logic [NW-1:0]        scaled_reg;
    logic [FREQ_BITS-1:0] div_reg;
    logic [RW-1:0]        rank_reg, last_reg;
    logic [FREQ_BITS-1:0] bnd_prev_reg, bnd_cur_reg;
    logic [UW-1:0]        used_reg;
    logic                 div_go_reg, div_pend_reg;

    // table memories, one write port and one read port each
    logic [FREQ_BITS-1:0] bound_mem [MAX_SYMBOLS];
    logic [7:0]           sym_mem [MAX_SYMBOLS];
    logic [FREQ_BITS-1:0] bound_rd_reg;
    logic [7:0]           sym_rd_reg;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;

    // output word
    logic       ovalid_reg;
    logic [7:0] osym_reg;
    logic       oeom_reg;
    logic [4:0] oused_reg;

    // shared divider
    ad16_pkg::div_ctl_t   dctl;
    logic [NW-1:0]        dnum, dquot;
    logic [CODE_BITS:0]   dden;
    logic                 ddone;
    logic [CODE_BITS:0]   span;

    assign span = {1'b0, span_m1_reg} + 1'b1;

    ad16_div #(.NW(NW), .DW(CODE_BITS + 1)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (dctl),
        .numer (dnum),
        .denom (dden),
        .done  (ddone),
        .quot  (dquot)
    );

    assign dctl.start = div_go_reg;
    assign dctl.busy  = div_pend_reg;

    // product for divider numerator: one multiply, registered by the divider
    logic [NW-1:0] prod_op_a;
    logic [NW-1:0] prod_op_b;
    always_comb
    begin
        prod_op_a = '0;
        prod_op_b = '0;
        dden      = span;
        if (state_reg == S_SCALE)
        begin
            prod_op_a = NW'({1'b0, code_reg - low_reg}) + 1'b1;
            prod_op_b = NW'(div_reg);
        end
        else if (state_reg == S_HIDIV)
        begin
            prod_op_a = NW'(bnd_cur_reg);
            prod_op_b = NW'(span);
            dden      = (CODE_BITS + 1)'(div_reg);
        end
        else
        begin
            prod_op_a = NW'(bnd_prev_reg);
            prod_op_b = NW'(span);
            dden      = (CODE_BITS + 1)'(div_reg);
        end
    end
    logic [NW-1:0] prod;
    assign prod = prod_op_a * prod_op_b;
    assign dnum = (state_reg == S_SCALE) ? prod - 1'b1 : prod;

    // channel accepts, ready and table write/read addressing
    logic in_acc, cfg_acc, out_acc;
    assign in_acc  = in_ch.valid && in_ch.ready;
    assign cfg_acc = cfg_ch.valid && cfg_ch.ready;
    assign out_acc = out_ch.valid && out_ch.ready;

    assign in_ch.ready  = (state_reg == S_IDLE) && !ovalid_reg;
    assign cfg_ch.ready = 1'b1;

    assign wr_en   = in_acc && (in_ch.cmd == ad16_pkg::CMD_LOAD) &&
                     (in_ch.entry_index != 9'd0) &&
                     ({1'b0, in_ch.entry_index} <= 10'(MAX_SYMBOLS));
    assign wr_addr = AW'(in_ch.entry_index - 9'd1);

    logic [RW-1:0] rm2;
    assign rm2 = rank_reg - RW'(2);
    assign rd_addr = rm2[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bound_mem[wr_addr] <= in_ch.entry_bound[FREQ_BITS-1:0];
            sym_mem[wr_addr]   <= in_ch.entry_symbol;
        end
        bound_rd_reg <= bound_mem[rd_addr];
        sym_rd_reg   <= sym_mem[rd_addr];
    end

    // renormalization step
    logic [CODE_BITS-1:0] rn_lo, rn_hi, rn_code;
    logic                 rn_go;
    always_comb
    begin
        rn_lo   = lo_w_reg;
        rn_hi   = hi_w_reg;
        rn_code = code_reg;
        rn_go   = 1'b1;
        if (hi_w_reg < HALFV)
        begin
            rn_go = 1'b1;
        end
        else if (lo_w_reg >= HALFV)
        begin
            rn_lo   = lo_w_reg - HALFV;
            rn_hi   = hi_w_reg - HALFV;
            rn_code = code_reg - HALFV;
        end
        else if (lo_w_reg >= QTRV && hi_w_reg < Q3V)
        begin
            rn_lo   = lo_w_reg - QTRV;
            rn_hi   = hi_w_reg - QTRV;
            rn_code = code_reg - QTRV;
        end
        else
        begin
            rn_go = 1'b0;
        end
    end

    logic [FREQ_BITS-1:0] cur_bound;
    assign cur_bound = (rank_reg == RW'(1)) ? FREQ_BITS'(1) : bound_rd_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && in_ch.cmd == ad16_pkg::CMD_DECODE)
                begin
                    state_next = S_SCALE;
                end
                else if (in_acc && in_ch.cmd == ad16_pkg::CMD_START)
                begin
                    state_next = S_OUT;
                end
            end
            S_SCALE:
            begin
                if (ddone)
                begin
                    state_next = S_SRCH;
                end
            end
            S_SRCH:  state_next = S_SRCHW;
            S_SRCHW:
            begin
                if (rank_reg < last_reg && NW'(cur_bound) <= scaled_reg)
                begin
                    state_next = S_SRCH;
                end
                else
                begin
                    state_next = S_HIDIV;
                end
            end
            S_HIDIV:
            begin
                if (ddone)
                begin
                    state_next = S_LODIV;
                end
            end
            S_LODIV:
            begin
                if (ddone)
                begin
                    state_next = S_RENORM;
                end
            end
            S_RENORM:
            begin
                if (!rn_go || used_reg == UW'(CODE_BITS))
                begin
                    state_next = S_SYM;
                end
            end
            S_SYM:   state_next = S_SYMW;
            S_SYMW:  state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_cfg_reg <= 9'd1;
            freq_cfg_reg  <= FREQ_BITS'(2);
            low_reg       <= '0;
            high_reg      <= '1;
            code_reg      <= '0;
            ovalid_reg    <= 1'b0;
            div_go_reg    <= 1'b0;
            div_pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            div_go_reg <= 1'b0;
            if (cfg_acc)
            begin
                if (cfg_ch.index == ad16_pkg::REG_SYMBOL_COUNT)
                begin
                    count_cfg_reg <= cfg_ch.data[8:0];
                end
                else
                begin
                    freq_cfg_reg <= FREQ_BITS'(cfg_ch.data);
                end
            end
            if (out_acc)
            begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && in_ch.cmd == ad16_pkg::CMD_START)
                    begin
                        low_reg  <= '0;
                        high_reg <= '1;
                        code_reg <= in_ch.code_window[CODE_BITS-1:0];
                    end
                    else if (in_acc && in_ch.cmd == ad16_pkg::CMD_DECODE)
                    begin
                        div_go_reg   <= 1'b1;
                        div_pend_reg <= 1'b1;
                    end
                end
                S_SCALE:
                begin
                    if (ddone)
                    begin
                        div_pend_reg <= 1'b0;
                    end
                end
                S_SRCHW:
                begin
                    if (!(rank_reg < last_reg && NW'(cur_bound) <= scaled_reg))
                    begin
                        div_go_reg   <= 1'b1;
                        div_pend_reg <= 1'b1;
                    end
                end
                S_HIDIV:
                begin
                    if (ddone)
                    begin
                        div_go_reg <= 1'b1;
                    end
                end
                S_LODIV:
                begin
                    if (ddone)
                    begin
                        div_pend_reg <= 1'b0;
                    end
                end
                S_RENORM:
                begin
                    if (rn_go && used_reg != UW'(CODE_BITS))
                    begin
                        code_reg <= {rn_code[CODE_BITS-2:0],
                                     window_reg[CODE_BITS-1]};
                    end
                end
                S_SYM:
                begin
                    low_reg  <= lo_w_reg;
                    high_reg <= hi_w_reg;
                end
                S_OUT:
                begin
                    ovalid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                window_reg  <= in_ch.code_window[CODE_BITS-1:0];
                span_m1_reg <= high_reg - low_reg;
                div_reg     <= (freq_cfg_reg == '0) ? FREQ_BITS'(1) : freq_cfg_reg;
                last_reg    <= (count_cfg_reg > 9'(MAX_SYMBOLS)) ?
                               RW'(MAX_SYMBOLS + 1) : RW'(count_cfg_reg) + RW'(1);
                rank_reg    <= RW'(1);
                bnd_prev_reg <= '0;
                used_reg    <= '0;
                // start answers with an empty symbol and a full window
                if (in_acc && in_ch.cmd == ad16_pkg::CMD_START)
                begin
                    osym_reg  <= 8'd0;
                    oeom_reg  <= 1'b0;
                    oused_reg <= 5'(CODE_BITS);
                end
            end
            S_SCALE:
            begin
                if (ddone)
                begin
                    scaled_reg <= dquot;
                end
            end
            S_SRCHW:
            begin
                bnd_cur_reg <= cur_bound;
                if (rank_reg < last_reg && NW'(cur_bound) <= scaled_reg)
                begin
                    bnd_prev_reg <= cur_bound;
                    rank_reg     <= rank_reg + RW'(1);
                end
            end
            S_HIDIV:
            begin
                if (ddone)
                begin
                    hi_w_reg <= low_reg + dquot[CODE_BITS-1:0] - 1'b1;
                end
            end
            S_LODIV:
            begin
                if (ddone)
                begin
                    lo_w_reg <= low_reg + dquot[CODE_BITS-1:0];
                end
            end
            S_RENORM:
            begin
                if (rn_go && used_reg != UW'(CODE_BITS))
                begin
                    lo_w_reg   <= {rn_lo[CODE_BITS-2:0], 1'b0};
                    hi_w_reg   <= {rn_hi[CODE_BITS-2:0], 1'b1};
                    window_reg <= {window_reg[CODE_BITS-2:0], 1'b0};
                    used_reg   <= used_reg + UW'(1);
                end
            end
            S_SYMW:
            begin
                // rank_reg still holds the found rank; sym read issued in S_SYM
                osym_reg  <= (rank_reg == RW'(1)) ? 8'd0 : sym_rd_reg;
                oeom_reg  <= (rank_reg == RW'(1));
                oused_reg <= 5'(used_reg);
            end
            default:
            begin
                scaled_reg <= scaled_reg;
            end
        endcase
    end

    assign out_ch.valid          = ovalid_reg;
    assign out_ch.symbol         = osym_reg;
    assign out_ch.end_of_message = oeom_reg;
    assign out_ch.bits_used      = oused_reg;

`ifndef SYNTHESIS
    // no new word taken while a result is pending
    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> !in_ch.ready)
        else $error("input accepted with result pending");
    // result held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid && $stable(out_ch.symbol))
        else $error("result dropped under stall");
    // bit count bounded
    a_used: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.bits_used <= 5'(CODE_BITS)))
        else $error("bits_used out of range");
`endif
endmodule
